// ===== sv/prq_pkg.sv =====
package prq_pkg;

   localparam int NUM_TASKS = 64;
   localparam int NUM_PRIO  = 140;
   localparam int TASK_W    = $clog2(NUM_TASKS);
   localparam int PRIO_W    = $clog2(NUM_PRIO);
   localparam int CNT_W     = $clog2(NUM_TASKS + 1);
   localparam int GRP_SIZE  = 16;
   localparam int NUM_GRP   = (NUM_PRIO + GRP_SIZE - 1) / GRP_SIZE;
   localparam int GRP_W     = (NUM_GRP > 1) ? $clog2(NUM_GRP) : 1;
   localparam int SLICE_W   = 9;

   localparam logic [2:0] POL_FIFO   = 3'd0;
   localparam logic [2:0] POL_RR     = 3'd1;
   localparam logic [2:0] POL_NORMAL = 3'd2;
   localparam logic [2:0] POL_BATCH  = 3'd3;
   localparam logic [2:0] POL_IDLE   = 3'd4;

   localparam logic [1:0] STAT_OK     = 2'd0;
   localparam logic [1:0] STAT_EMPTY  = 2'd1;
   localparam logic [1:0] STAT_REJECT = 2'd2;

   localparam logic FUNC_ENQUEUE  = 1'b0;
   localparam logic FUNC_SCHEDULE = 1'b1;

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_FIND     = 8'b0000_0010,
      ST_POP_RD   = 8'b0000_0100,
      ST_POP_LINK = 8'b0000_1000,
      ST_POP_WR   = 8'b0001_0000,
      ST_PUSH_RD  = 8'b0010_0000,
      ST_PUSH_WR  = 8'b0100_0000,
      ST_RESP     = 8'b1000_0000
   } state_type;

   typedef struct packed {
      logic ld_in;
      logic ld_grp;
      logic pop_rd;
      logic pop_link;
      logic pop_wr;
      logic push_rd;
      logic push_wr;
      logic resp;
   } cmd_type;

   typedef struct packed {
      logic is_sched;
      logic enq_ok;
      logic push_needed;
   } stat_type;

   // Slice by policy; NORMAL is 100*(140-prio)/40 = 5*(140-prio)/2.
   function automatic logic [SLICE_W-1:0] slice_for(input logic [2:0] pol,
                                                    input logic [7:0] prio);
      logic [10:0] diff5;
      logic [SLICE_W-1:0] res;
      diff5 = 11'd0;
      res   = '0;
      case (pol)
         POL_FIFO:   res = SLICE_W'(200);
         POL_RR:     res = SLICE_W'(100);
         POL_NORMAL: begin
            if (prio < 8'd140) begin
               diff5 = 11'd700 - (11'(prio) * 11'd5);
               res   = SLICE_W'(diff5 >> 1);
            end
         end
         POL_BATCH:  res = SLICE_W'(200);
         POL_IDLE:   res = SLICE_W'(10);
         default:    res = '0;
      endcase
      return res;
   endfunction

endpackage

// ===== sv/prq_ram.sv =====
module prq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/prq_ctrl.sv =====
module prq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  prq_pkg::stat_type stat,
   output prq_pkg::cmd_type  cmd
);

   prq_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         prq_pkg::ST_IDLE:     if (start) state_in = prq_pkg::ST_FIND;
         prq_pkg::ST_FIND: begin
            if (stat.is_sched) state_in = prq_pkg::ST_POP_RD;
            else if (stat.enq_ok) state_in = prq_pkg::ST_PUSH_RD;
            else state_in = prq_pkg::ST_RESP;
         end
         prq_pkg::ST_POP_RD:   state_in = prq_pkg::ST_POP_LINK;
         prq_pkg::ST_POP_LINK: state_in = prq_pkg::ST_POP_WR;
         prq_pkg::ST_POP_WR: begin
            state_in = stat.push_needed ? prq_pkg::ST_PUSH_WR : prq_pkg::ST_RESP;
         end
         prq_pkg::ST_PUSH_RD:  state_in = prq_pkg::ST_PUSH_WR;
         prq_pkg::ST_PUSH_WR:  state_in = prq_pkg::ST_RESP;
         prq_pkg::ST_RESP:     state_in = prq_pkg::ST_IDLE;
         default:              state_in = prq_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy         = (state_ff != prq_pkg::ST_IDLE);
   assign cmd.ld_in    = (state_ff == prq_pkg::ST_IDLE) && start;
   assign cmd.ld_grp   = (state_ff == prq_pkg::ST_FIND);
   assign cmd.pop_rd   = (state_ff == prq_pkg::ST_POP_RD);
   assign cmd.pop_link = (state_ff == prq_pkg::ST_POP_LINK);
   assign cmd.pop_wr   = (state_ff == prq_pkg::ST_POP_WR);
   assign cmd.push_rd  = (state_ff == prq_pkg::ST_PUSH_RD);
   assign cmd.push_wr  = (state_ff == prq_pkg::ST_PUSH_WR);
   assign cmd.resp     = (state_ff == prq_pkg::ST_RESP);

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("controller state is not one-hot");
   a_resp_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.resp |=> (state_ff == prq_pkg::ST_IDLE))
      else $error("response not followed by idle");
   a_accept: assert property (@(posedge clock) disable iff (reset)
      cmd.ld_in |=> (state_ff == prq_pkg::ST_FIND))
      else $error("accepted word did not start work");

endmodule

// ===== sv/prq_dpath.sv =====
module prq_dpath (
   input  logic                           clock,
   input  logic                           reset,
   input  prq_pkg::cmd_type               cmd,
   output prq_pkg::stat_type              stat,
   input  logic                           req_func,
   input  logic [5:0]                     req_task_id,
   input  logic [7:0]                     req_prio_level,
   input  logic [2:0]                     req_policy,
   input  logic                           req_prev_runnable,
   output logic                           rsp_valid,
   output logic [1:0]                     rsp_status,
   output logic                           rsp_picked_valid,
   output logic [5:0]                     rsp_picked_task,
   output logic [8:0]                     rsp_slice_ms,
   output logic [6:0]                     rsp_queued_count
);

   localparam int TW = prq_pkg::TASK_W;
   localparam int PW = prq_pkg::PRIO_W;
   localparam int CW = prq_pkg::CNT_W;
   localparam int NG = prq_pkg::NUM_GRP;
   localparam int GS = prq_pkg::GRP_SIZE;

   // Latched request word.
   logic          func_ff;
   logic [5:0]    tid_ff;
   logic [7:0]    prio_ff;
   logic [2:0]    pol_ff;
   logic          run_ff;

   logic [prq_pkg::NUM_PRIO-1:0] occ_ff, occ_in;
   logic [CW-1:0] count_ff, count_in;
   logic          cur_valid_ff, cur_valid_in;
   logic [TW-1:0] cur_ff, cur_in;

   // First stage of the occupancy search, one entry per group of levels.
   logic [NG-1:0] grp_any_ff, grp_any_in;
   logic [3:0]    grp_idx_ff [NG];
   logic [3:0]    grp_idx_in [NG];
   logic [NG*GS-1:0] occ_pad;

   logic          found_ff, found_in;
   logic [PW-1:0] pop_prio_ff, pop_prio_in;
   logic [TW-1:0] next_ff;
   logic [7:0]    cur_prio_ff;
   logic [8:0]    slice_ff;
   logic          fwd_ff;
   logic [TW-1:0] fwd_val_ff;
   logic [PW-1:0] push_prio_ff;
   logic [TW-1:0] push_slot_ff;

   // Memory ports.
   logic          head_we;
   logic [PW-1:0] head_waddr, head_raddr;
   logic [TW-1:0] head_wdata, head_rdata;
   logic          link_we;
   logic [TW-1:0] link_waddr, link_raddr;
   logic [TW:0]   link_wdata, link_rdata;
   logic          slot_we;
   logic [TW-1:0] slot_waddr, slot_raddr;
   logic [10:0]   slot_wdata, slot_rdata;

   logic          link_end;
   logic [TW-1:0] link_nxt;
   logic [TW-1:0] head_old;
   logic          enq_ok;
   // The push changes the count, so the verdict is kept from before it.
   logic          enq_ok_ff;

   prq_ram #(.WIDTH(TW), .DEPTH(prq_pkg::NUM_PRIO)) u_head (
      .clock(clock), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
      .raddr(head_raddr), .rdata(head_rdata));
   prq_ram #(.WIDTH(TW + 1), .DEPTH(prq_pkg::NUM_TASKS)) u_link (
      .clock(clock), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
      .raddr(link_raddr), .rdata(link_rdata));
   prq_ram #(.WIDTH(11), .DEPTH(prq_pkg::NUM_TASKS)) u_slot (
      .clock(clock), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
      .raddr(slot_raddr), .rdata(slot_rdata));

   assign link_end = link_rdata[TW];
   assign link_nxt = link_rdata[TW-1:0];
   assign head_old = fwd_ff ? fwd_val_ff : head_rdata;

   assign enq_ok = (prio_ff < 8'(prq_pkg::NUM_PRIO)) && (pol_ff <= prq_pkg::POL_IDLE) &&
                   (7'(tid_ff) < 7'(prq_pkg::NUM_TASKS)) &&
                   (count_ff < CW'(prq_pkg::NUM_TASKS));

   assign stat.is_sched    = (func_ff == prq_pkg::FUNC_SCHEDULE);
   assign stat.enq_ok      = enq_ok;
   assign stat.push_needed = cur_valid_ff && run_ff &&
                             (cur_prio_ff < 8'(prq_pkg::NUM_PRIO));

   assign occ_pad = (NG*GS)'(occ_ff);

   always_comb begin
      for (int g = 0; g < NG; g++) begin
         grp_any_in[g] = |occ_pad[g*GS +: GS];
         grp_idx_in[g] = 4'd0;
         for (int i = GS - 1; i >= 0; i--) begin
            if (occ_pad[g*GS + i]) grp_idx_in[g] = 4'(i);
         end
      end
   end

   // Second stage: lowest occupied group.
   always_comb begin
      found_in    = 1'b0;
      pop_prio_in = '0;
      for (int g = NG - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            found_in    = 1'b1;
            pop_prio_in = PW'((g * GS) + int'(grp_idx_ff[g]));
         end
      end
   end

   always_comb begin
      head_raddr = pop_prio_in;
      if (cmd.pop_wr) head_raddr = PW'(cur_prio_ff);
      else if (cmd.push_rd) head_raddr = PW'(prio_ff);

      head_we    = 1'b0;
      head_waddr = pop_prio_ff;
      head_wdata = link_nxt;
      if (cmd.pop_wr && found_ff && !link_end) begin
         head_we = 1'b1;
      end else if (cmd.push_wr) begin
         head_we    = 1'b1;
         head_waddr = push_prio_ff;
         head_wdata = push_slot_ff;
      end

      link_raddr = head_rdata;
      link_we    = cmd.push_wr;
      link_waddr = push_slot_ff;
      link_wdata = {!occ_ff[push_prio_ff], head_old};

      slot_raddr = cmd.pop_rd ? cur_ff : head_rdata;
      slot_we    = cmd.push_rd;
      slot_waddr = TW'(tid_ff);
      slot_wdata = {prio_ff, pol_ff};
   end

   always_comb begin
      occ_in       = occ_ff;
      count_in     = count_ff;
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      if (cmd.pop_wr) begin
         if (found_ff) begin
            if (link_end) occ_in[pop_prio_ff] = 1'b0;
            if (count_ff != '0) count_in = count_ff - CW'(1);
         end
         cur_valid_in = found_ff;
         cur_in       = found_ff ? next_ff : '0;
      end
      if (cmd.push_wr) begin
         occ_in[push_prio_ff] = 1'b1;
         if (count_ff < CW'(prq_pkg::NUM_TASKS)) count_in = count_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         count_ff     <= '0;
         cur_valid_ff <= 1'b0;
         cur_ff       <= '0;
      end else begin
         occ_ff       <= occ_in;
         count_ff     <= count_in;
         cur_valid_ff <= cur_valid_in;
         cur_ff       <= cur_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_in) begin
         func_ff <= req_func;
         tid_ff  <= req_task_id;
         prio_ff <= req_prio_level;
         pol_ff  <= req_policy;
         run_ff  <= req_prev_runnable;
      end
      if (cmd.ld_grp) begin
         grp_any_ff <= grp_any_in;
         grp_idx_ff <= grp_idx_in;
         found_ff   <= 1'b0;
         enq_ok_ff  <= enq_ok;
      end
      if (cmd.pop_rd) begin
         found_ff    <= found_in;
         pop_prio_ff <= pop_prio_in;
      end
      if (cmd.pop_link) begin
         next_ff     <= head_rdata;
         cur_prio_ff <= slot_rdata[10:3];
      end
      if (cmd.pop_wr) begin
         slice_ff     <= prq_pkg::slice_for(slot_rdata[2:0], slot_rdata[10:3]);
         // The head read this cycle misses the pop write to the same level.
         fwd_ff       <= found_ff && !link_end && (PW'(cur_prio_ff) == pop_prio_ff);
         fwd_val_ff   <= link_nxt;
         push_prio_ff <= PW'(cur_prio_ff);
         push_slot_ff <= cur_ff;
      end
      if (cmd.push_rd) begin
         fwd_ff       <= 1'b0;
         push_prio_ff <= PW'(prio_ff);
         push_slot_ff <= TW'(tid_ff);
      end
   end

   always_comb begin
      rsp_valid        = cmd.resp;
      rsp_picked_valid = stat.is_sched && found_ff;
      rsp_picked_task  = rsp_picked_valid ? 6'(next_ff) : 6'd0;
      rsp_slice_ms     = rsp_picked_valid ? slice_ff : 9'd0;
      rsp_queued_count = 7'(count_ff);
      if (stat.is_sched) rsp_status = found_ff ? prq_pkg::STAT_OK : prq_pkg::STAT_EMPTY;
      else rsp_status = enq_ok_ff ? prq_pkg::STAT_OK : prq_pkg::STAT_REJECT;
   end

   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(prq_pkg::NUM_TASKS))
      else $error("queue count above pool size");
   a_push_occ: assert property (@(posedge clock) disable iff (reset)
      cmd.push_wr |=> occ_ff[$past(push_prio_ff)])
      else $error("push left its level unoccupied");
   a_pick_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_picked_valid) |-> (rsp_status == prq_pkg::STAT_OK))
      else $error("picked task with non-ok status");

endmodule

// ===== sv/priority_bitmap_run_queue_top.sv =====
// Channel   | Ports                                  | Handshake
// request   | req_func .. req_prev_runnable          | start high, busy low
// response  | rsp_status .. rsp_queued_count         | rsp_valid, one cycle
// Enqueue steps: find, push read, push write, response, or find, response if
// rejected. Schedule: find, pop read, pop link, pop write, push write if the
// old task goes back, response. Registered head, link, slot reads set them.
// Busy drops the cycle after the response, so the next word is taken then.
// Synchronous reset empties the queue and clears the current task.
// The receiver cannot stall; busy stays high until the response cycle ends.
module priority_bitmap_run_queue_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic       req_func,
   input  logic [5:0] req_task_id,
   input  logic [7:0] req_prio_level,
   input  logic [2:0] req_policy,
   input  logic       req_prev_runnable,
   output logic       rsp_valid,
   output logic [1:0] rsp_status,
   output logic       rsp_picked_valid,
   output logic [5:0] rsp_picked_task,
   output logic [8:0] rsp_slice_ms,
   output logic [6:0] rsp_queued_count
);

   prq_pkg::cmd_type  cmd;
   prq_pkg::stat_type stat;

   prq_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .stat(stat), .cmd(cmd));

   prq_dpath u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_func(req_func), .req_task_id(req_task_id),
      .req_prio_level(req_prio_level), .req_policy(req_policy),
      .req_prev_runnable(req_prev_runnable),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_picked_valid(rsp_picked_valid), .rsp_picked_task(rsp_picked_task),
      .rsp_slice_ms(rsp_slice_ms), .rsp_queued_count(rsp_queued_count));

endmodule

// ===== test/tb_priority_bitmap_run_queue_top.sv =====
`timescale 1ns / 1ps

module tb_priority_bitmap_run_queue_top;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_WORDS   = 290;

   typedef struct packed {
      logic       func;
      logic [5:0] task_id;
      logic [7:0] prio_level;
      logic [2:0] policy;
      logic       prev_runnable;
   } sched_cmd_type;

   typedef struct packed {
      logic [1:0] status;
      logic       picked_valid;
      logic [5:0] picked_task;
      logic [8:0] slice_ms;
      logic [6:0] queued_count;
   } sched_rsp_type;

   typedef struct {
      sched_cmd_type cmd;
      logic          has_golden;
      sched_rsp_type golden;
   } directed_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic       req_func = 1'b0;
   logic [5:0] req_task_id = '0;
   logic [7:0] req_prio_level = '0;
   logic [2:0] req_policy = '0;
   logic       req_prev_runnable = 1'b0;
   logic       rsp_valid;
   logic [1:0] rsp_status;
   logic       rsp_picked_valid;
   logic [5:0] rsp_picked_task;
   logic [8:0] rsp_slice_ms;
   logic [6:0] rsp_queued_count;

   priority_bitmap_run_queue_top i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_func(req_func), .req_task_id(req_task_id),
      .req_prio_level(req_prio_level), .req_policy(req_policy),
      .req_prev_runnable(req_prev_runnable), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_picked_valid(rsp_picked_valid),
      .rsp_picked_task(rsp_picked_task), .rsp_slice_ms(rsp_slice_ms),
      .rsp_queued_count(rsp_queued_count)
   );

   always #4 clock = ~clock;

   // Shadow copy of the run queue.
   logic [5:0] head_slot [prq_pkg::NUM_PRIO];
   logic [5:0] next_slot [prq_pkg::NUM_TASKS];
   logic       tail_mark [prq_pkg::NUM_TASKS];
   logic [7:0] task_prio [prq_pkg::NUM_TASKS];
   logic [2:0] task_pol  [prq_pkg::NUM_TASKS];
   logic       level_busy [prq_pkg::NUM_PRIO];
   int         run_count;
   logic       cur_valid;
   logic [5:0] cur_task;

   sched_rsp_type expected_rsps [$];
   int mismatches = 0;
   int words_sent = 0;
   int enq_count = 0, sched_count = 0, idle_picks = 0, rejects = 0;
   int quiet_cycles = 0;

   function automatic logic [8:0] policy_slice(logic [2:0] pol, logic [7:0] prio);
      case (pol)
         prq_pkg::POL_FIFO, prq_pkg::POL_BATCH: return 9'd200;
         prq_pkg::POL_RR:                       return 9'd100;
         prq_pkg::POL_NORMAL:
            return (prio >= 8'd140) ? 9'd0 : 9'((100 * (140 - prio)) / 40);
         prq_pkg::POL_IDLE:                     return 9'd10;
         default:                               return 9'd0;
      endcase
   endfunction

   task automatic link_in(logic [5:0] slot);
      logic [7:0] p;
      p = task_prio[slot];
      if (p >= prq_pkg::NUM_PRIO) return;
      next_slot[slot] = level_busy[p] ? head_slot[p] : 6'd0;
      tail_mark[slot] = !level_busy[p];
      head_slot[p] = slot;
      level_busy[p] = 1'b1;
      if (run_count < prq_pkg::NUM_TASKS) run_count++;
   endtask

   task automatic predict_queue(sched_cmd_type c, output sched_rsp_type r);
      logic found;
      logic [5:0] pick;
      int lvl;
      r = '0;
      found = 1'b0;
      pick = '0;
      if (c.func == prq_pkg::FUNC_ENQUEUE) begin
         enq_count++;
         if (c.prio_level >= prq_pkg::NUM_PRIO || c.policy > prq_pkg::POL_IDLE ||
             run_count >= prq_pkg::NUM_TASKS) begin
            r.status = prq_pkg::STAT_REJECT;
            rejects++;
         end else begin
            task_prio[c.task_id] = c.prio_level;
            task_pol[c.task_id] = c.policy;
            link_in(c.task_id);
         end
      end else begin
         sched_count++;
         for (lvl = 0; lvl < prq_pkg::NUM_PRIO && !found; lvl++) begin
            if (level_busy[lvl]) begin
               found = 1'b1;
               pick = head_slot[lvl];
               if (tail_mark[pick]) level_busy[lvl] = 1'b0;
               else head_slot[lvl] = next_slot[pick];
            end
         end
         if (found) begin
            if (run_count > 0) run_count--;
            r.picked_valid = 1'b1;
            r.picked_task = pick;
            r.slice_ms = policy_slice(task_pol[pick], task_prio[pick]);
         end else begin
            r.status = prq_pkg::STAT_EMPTY;
            idle_picks++;
         end
         if (cur_valid && c.prev_runnable) link_in(cur_task);
         cur_valid = found;
         cur_task = found ? pick : 6'd0;
      end
      r.queued_count = 7'(run_count);
   endtask

   task automatic issue_word(sched_cmd_type c, logic has_golden, sched_rsp_type golden);
      sched_rsp_type r;
      predict_queue(c, r);
      if (has_golden && r !== golden) begin
         mismatches++;
         if (mismatches <= 10)
            $display("table row disagrees with prediction: table %h predicted %h",
                     golden, r);
      end
      expected_rsps.push_back(r);
      start <= 1'b1;
      req_func <= c.func;
      req_task_id <= c.task_id;
      req_prio_level <= c.prio_level;
      req_policy <= c.policy;
      req_prev_runnable <= c.prev_runnable;
      do @(posedge clock); while (busy);
      words_sent++;
   endtask

   function automatic sched_cmd_type random_cmd();
      sched_cmd_type c;
      c.func = ($urandom_range(99) < 55) ? prq_pkg::FUNC_ENQUEUE : prq_pkg::FUNC_SCHEDULE;
      c.task_id = 6'($urandom);
      c.prio_level = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 140))
                   : ($urandom_range(3) == 0) ? 8'($urandom_range(7))
                                              : 8'($urandom_range(139));
      c.policy = ($urandom_range(15) == 0) ? 3'($urandom_range(7, 5))
                                           : 3'($urandom_range(4));
      c.prev_runnable = 1'($urandom);
      return c;
   endfunction

   // Results are sampled at the edge that ends their cycle.
   always @(posedge clock) begin
      sched_rsp_type got, want;
      if (!reset && rsp_valid) begin
         got = {rsp_status, rsp_picked_valid, rsp_picked_task, rsp_slice_ms,
                rsp_queued_count};
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response word %h", got);
         end else begin
            want = expected_rsps.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("response mismatch: expected st=%0d pv=%0d pt=%0d sl=%0d qc=%0d",
                     want.status, want.picked_valid, want.picked_task, want.slice_ms,
                     want.queued_count);
                  $display("                   got      st=%0d pv=%0d pt=%0d sl=%0d qc=%0d",
                     got.status, got.picked_valid, got.picked_task, got.slice_ms,
                     got.queued_count);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d responses outstanding", expected_rsps.size());
         $display("priority_bitmap_run_queue_top: mismatch");
         $finish;
      end
   end

   directed_row_type rows [$];

   function automatic directed_row_type mk(logic f, int tid, int pr, int pol, logic run,
                                           logic g = 1'b0, sched_rsp_type gr = '0);
      directed_row_type d;
      d.cmd = '{f, 6'(tid), 8'(pr), 3'(pol), run};
      d.has_golden = g;
      d.golden = gr;
      return d;
   endfunction

   initial begin
      int i, j;
      sched_cmd_type c;
      for (i = 0; i < prq_pkg::NUM_PRIO; i++) level_busy[i] = 1'b0;
      for (i = 0; i < prq_pkg::NUM_TASKS; i++) begin
         next_slot[i] = '0; tail_mark[i] = 1'b0; task_prio[i] = '0; task_pol[i] = '0;
      end
      run_count = 0; cur_valid = 1'b0; cur_task = '0;

      // Idle schedule right after reset, then the field extremes and rejects.
      rows.push_back(mk(prq_pkg::FUNC_SCHEDULE, 63, 255, 7, 1, 1,
                        '{prq_pkg::STAT_EMPTY, 0, 0, 0, 0}));
      rows.push_back(mk(prq_pkg::FUNC_ENQUEUE, 0, 140, prq_pkg::POL_FIFO, 0, 1,
                        '{prq_pkg::STAT_REJECT, 0, 0, 0, 0}));
      rows.push_back(mk(prq_pkg::FUNC_ENQUEUE, 0, 255, prq_pkg::POL_FIFO, 0, 1,
                        '{prq_pkg::STAT_REJECT, 0, 0, 0, 0}));
      rows.push_back(mk(prq_pkg::FUNC_ENQUEUE, 0, 5, 7, 0, 1,
                        '{prq_pkg::STAT_REJECT, 0, 0, 0, 0}));
      rows.push_back(mk(prq_pkg::FUNC_ENQUEUE, 0, 5, 5, 1, 1,
                        '{prq_pkg::STAT_REJECT, 0, 0, 0, 0}));
      rows.push_back(mk(prq_pkg::FUNC_ENQUEUE, 63, 139, prq_pkg::POL_NORMAL, 0, 1,
                        '{prq_pkg::STAT_OK, 0, 0, 0, 1}));
      rows.push_back(mk(prq_pkg::FUNC_ENQUEUE, 0, 0, prq_pkg::POL_FIFO, 0, 1,
                        '{prq_pkg::STAT_OK, 0, 0, 0, 2}));
      rows.push_back(mk(prq_pkg::FUNC_ENQUEUE, 1, 0, prq_pkg::POL_RR, 0));
      rows.push_back(mk(prq_pkg::FUNC_ENQUEUE, 2, 20, prq_pkg::POL_BATCH, 0));
      rows.push_back(mk(prq_pkg::FUNC_ENQUEUE, 3, 100, prq_pkg::POL_IDLE, 0));
      rows.push_back(mk(prq_pkg::FUNC_ENQUEUE, 4, 0, prq_pkg::POL_NORMAL, 1));
      rows.push_back(mk(prq_pkg::FUNC_SCHEDULE, 42, 200, 6, 0));
      rows.push_back(mk(prq_pkg::FUNC_SCHEDULE, 0, 0, 0, 1));
      rows.push_back(mk(prq_pkg::FUNC_SCHEDULE, 0, 0, 0, 1));
      // A duplicate enqueue of a task that is already queued.
      rows.push_back(mk(prq_pkg::FUNC_ENQUEUE, 1, 60, prq_pkg::POL_NORMAL, 0));
      for (i = 0; i < 8; i++) rows.push_back(mk(prq_pkg::FUNC_SCHEDULE, 0, 0, 0, i[0]));
      rows.push_back(mk(prq_pkg::FUNC_SCHEDULE, 0, 0, 0, 1));
      rows.push_back(mk(prq_pkg::FUNC_SCHEDULE, 0, 0, 0, 0));

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[k]) issue_word(rows[k].cmd, rows[k].has_golden, rows[k].golden);

      // Fill the pool to the top so the full-pool reject is reached.
      for (i = 0; i < 66; i++) begin
         c = random_cmd();
         c.func = prq_pkg::FUNC_ENQUEUE;
         c.prio_level = 8'($urandom_range(139));
         c.policy = 3'($urandom_range(4));
         issue_word(c, 1'b0, '0);
      end
      for (i = 0; i < 70; i++) begin
         c = random_cmd();
         c.func = prq_pkg::FUNC_SCHEDULE;
         issue_word(c, 1'b0, '0);
      end

      for (i = 0; i < RANDOM_WORDS; i++) begin
         // Idle gaps everywhere except in one quiet stretch.
         if ((i < 150 || i > 250) && $urandom_range(99) < 16) begin
            start <= 1'b0;
            j = $urandom_range(4, 1);
            repeat (j) @(posedge clock);
         end
         issue_word(random_cmd(), 1'b0, '0);
      end
      start <= 1'b0;

      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("Sent %0d words: %0d enqueues (%0d rejected), %0d schedules (%0d idle).",
               words_sent, enq_count, rejects, sched_count, idle_picks);
      if (mismatches == 0) $display("priority_bitmap_run_queue_top: match");
      else begin
         $display("%0d mismatches in total", mismatches);
         $display("priority_bitmap_run_queue_top: mismatch");
      end
      $finish;
   end

endmodule
